[rtl/lpwd_pkg.sv]
`default_nettype none

package lpwd_pkg;

    localparam int ACT_W  = 2;
    localparam int WORD_W = 32;
    localparam int RIDX_W = 6;
    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 16;

    localparam int STORE_DEPTH_DEF = 64;

    localparam logic [ACT_W-1:0] ACT_DATA  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PADDING = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DECODED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

    localparam logic [7:0] SYM_00 = 8'h88;
    localparam logic [7:0] SYM_01 = 8'h8e;
    localparam logic [7:0] SYM_10 = 8'he8;
    localparam logic [7:0] SYM_11 = 8'hee;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] byte_val;
    } t_word_dec;

    typedef struct packed {
        logic [KIND_W-1:0] word_kind;
        logic [BYTE_W-1:0] decoded_byte;
        logic [CNT_W-1:0]  byte_total;
        logic [CNT_W-1:0]  padding_total;
        logic [CNT_W-1:0]  invalid_total;
    } t_result;

    typedef struct packed {
        t_result           res;
        logic [BYTE_W-1:0] stored_byte;
    } t_out;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
        return (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
    endfunction

    // four parallel symbol compares, symbol in the low byte gives the low bits
    function automatic t_word_dec decode_word(input logic [WORD_W-1:0] word);
        t_word_dec  dec;
        logic [7:0] sym;
        dec.ok       = 1'b1;
        dec.byte_val = '0;
        for (int k = 0; k < 4; k++) begin
            sym = word[k*8 +: 8];
            unique case (sym)
                SYM_00: dec.byte_val[k*2 +: 2] = 2'd0;
                SYM_01: dec.byte_val[k*2 +: 2] = 2'd1;
                SYM_10: dec.byte_val[k*2 +: 2] = 2'd2;
                SYM_11: dec.byte_val[k*2 +: 2] = 2'd3;
                default: dec.ok = 1'b0;
            endcase
        end
        return dec;
    endfunction

endpackage

`default_nettype wire

[rtl/lpwd_in_if.sv]
`default_nettype none

interface lpwd_in_if import lpwd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [WORD_W-1:0] word;
    logic [RIDX_W-1:0] read_index;

    modport source (output valid, output action, output word, output read_index,
                    input ready);
    modport sink   (input valid, input action, input word, input read_index,
                    output ready);
endinterface

`default_nettype wire

[rtl/lpwd_out_if.sv]
`default_nettype none

interface lpwd_out_if import lpwd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] word_kind;
    logic [BYTE_W-1:0] decoded_byte;
    logic [CNT_W-1:0]  byte_total;
    logic [CNT_W-1:0]  padding_total;
    logic [CNT_W-1:0]  invalid_total;
    logic [BYTE_W-1:0] stored_byte;

    modport source (output valid, output word_kind, output decoded_byte,
                    output byte_total, output padding_total, output invalid_total,
                    output stored_byte, input ready);
    modport sink   (input valid, input word_kind, input decoded_byte,
                    input byte_total, input padding_total, input invalid_total,
                    input stored_byte, output ready);
endinterface

`default_nettype wire

[rtl/lpwd_byte_store.sv]
`default_nettype none

module lpwd_byte_store import lpwd_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no new read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/led_pulse_word_decoder.sv]
// results pass through the first result stage (r_a) and then the output register (r_b)
// throughput: one request per cycle while the output is not stalled by o_res.ready; the decode,
//   counter update and store access all sit between the request edge and the first result register
// reset (synchronous, active low) clears the counters, dma enable and valid flags;
//   the byte store is not swept, entries at or above the byte count read as zero
`default_nettype none

module led_pulse_word_decoder import lpwd_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    lpwd_in_if.sink     i_req,
    lpwd_out_if.source  o_res
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_W = CNT_W'(STORE_DEPTH);

    logic             r_dma_en;
    logic [CNT_W-1:0] r_byte_cnt, n_byte_cnt;
    logic [CNT_W-1:0] r_pad_cnt, n_pad_cnt;
    logic [CNT_W-1:0] r_inv_cnt, n_inv_cnt;

    logic    r_a_valid;
    t_result r_a, n_a;
    logic    r_a_rd_hit, n_rd_hit;
    logic    r_b_valid;
    t_out    r_b;

    logic              acc;
    logic              a_to_b;
    logic              mem_we;
    logic [BYTE_W-1:0] mem_q;
    t_word_dec         dec;
    logic [CNT_W-1:0]  ridx_w;
    logic [AW+RIDX_W-1:0] ridx_ext;

    assign a_to_b      = r_a_valid && (!r_b_valid || o_res.ready);
    assign i_req.ready = !r_a_valid || a_to_b;
    assign acc         = i_req.valid && i_req.ready;

    assign dec      = decode_word(i_req.word);
    assign ridx_w   = CNT_W'(i_req.read_index);
    assign ridx_ext = {AW'(0), i_req.read_index};

    always_comb begin
        n_byte_cnt = r_byte_cnt;
        n_pad_cnt  = r_pad_cnt;
        n_inv_cnt  = r_inv_cnt;
        n_rd_hit   = 1'b0;
        mem_we     = 1'b0;
        n_a.word_kind    = KIND_NONE;
        n_a.decoded_byte = '0;
        case (i_req.action)
            ACT_DATA: begin
                if (r_dma_en) begin
                    if (i_req.word == '0) begin
                        n_pad_cnt     = sat_inc(r_pad_cnt);
                        n_a.word_kind = KIND_PADDING;
                    end else if (dec.ok) begin
                        mem_we           = (r_byte_cnt < DEPTH_W);
                        n_byte_cnt       = sat_inc(r_byte_cnt);
                        n_a.word_kind    = KIND_DECODED;
                        n_a.decoded_byte = dec.byte_val;
                    end else begin
                        n_inv_cnt     = sat_inc(r_inv_cnt);
                        n_a.word_kind = KIND_INVALID;
                    end
                end
            end
            ACT_FLUSH: begin
                if (i_req.word != '0) begin
                    n_byte_cnt = '0;
                    n_pad_cnt  = '0;
                    n_inv_cnt  = '0;
                end
            end
            ACT_READ: begin
                // entries are filled in order from zero, so the count marks what is live
                n_rd_hit = (ridx_w < DEPTH_W) && (ridx_w < r_byte_cnt);
            end
            default: begin
            end
        endcase
        n_a.byte_total    = n_byte_cnt;
        n_a.padding_total = n_pad_cnt;
        n_a.invalid_total = n_inv_cnt;
    end

    lpwd_byte_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (acc && mem_we),
        .i_waddr (r_byte_cnt[AW-1:0]),
        .i_wdata (dec.byte_val),
        .i_re    (acc),
        .i_raddr (ridx_ext[AW-1:0]),
        .o_rdata (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dma_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_dma_en <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt <= '0;
            r_pad_cnt  <= '0;
            r_inv_cnt  <= '0;
        end else if (acc) begin
            r_byte_cnt <= n_byte_cnt;
            r_pad_cnt  <= n_pad_cnt;
            r_inv_cnt  <= n_inv_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_a_valid <= 1'b1;
            end else if (a_to_b) begin
                r_a_valid <= 1'b0;
            end
            if (a_to_b) begin
                r_b_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a        <= n_a;
            r_a_rd_hit <= n_rd_hit;
        end
        if (a_to_b) begin
            r_b.res         <= r_a;
            r_b.stored_byte <= r_a_rd_hit ? mem_q : '0;
        end
    end

    assign o_res.valid         = r_b_valid;
    assign o_res.word_kind     = r_b.res.word_kind;
    assign o_res.decoded_byte  = r_b.res.decoded_byte;
    assign o_res.byte_total    = r_b.res.byte_total;
    assign o_res.padding_total = r_b.res.padding_total;
    assign o_res.invalid_total = r_b.res.invalid_total;
    assign o_res.stored_byte   = r_b.stored_byte;

    // a held result in the first stage is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_a_valid) |-> a_to_b)
        else $error("first result stage overwritten");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.action == ACT_FLUSH && i_req.word != '0) |=>
        (r_byte_cnt == '0 && r_pad_cnt == '0 && r_inv_cnt == '0))
        else $error("flush did not clear counters");

    a_byte_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.action != ACT_FLUSH) |=> (r_byte_cnt >= $past(r_byte_cnt)))
        else $error("byte count went down without a flush");

    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && mem_we) |-> (r_byte_cnt < DEPTH_W))
        else $error("store written beyond its depth");

endmodule

`default_nettype wire
